/* sv/pl0_pkg.sv */
// package: payload types, token codes, character codes and keyword table for the pl0 lexer
`timescale 1ns / 1ps
package pl0_pkg;

  localparam int LexDepth  = 11;
  localparam int IdChars   = 11;
  localparam int NumDigits = 5;
  localparam int KwCount   = 14;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } pl0_in_t;

  typedef struct packed {
    logic [5:0]  token_type;
    logic [1:0]  error_kind;
    logic [3:0]  lexeme_length;
    logic [63:0] lexeme_head;
    logic [23:0] lexeme_tail;
    logic        last;
  } pl0_out_t;

  typedef struct packed {
    logic     push0;
    logic     push1;
    pl0_out_t res0;
    pl0_out_t res1;
  } pl0_res_pair_t;

  // token numbers
  localparam logic [5:0] TOK_ERR     = 6'd0;
  localparam logic [5:0] TOK_IDENT   = 6'd2;
  localparam logic [5:0] TOK_NUMBER  = 6'd3;
  localparam logic [5:0] TOK_PLUS    = 6'd4;
  localparam logic [5:0] TOK_MINUS   = 6'd5;
  localparam logic [5:0] TOK_MULT    = 6'd6;
  localparam logic [5:0] TOK_SLASH   = 6'd7;
  localparam logic [5:0] TOK_EQL     = 6'd9;
  localparam logic [5:0] TOK_NEQ     = 6'd10;
  localparam logic [5:0] TOK_LES     = 6'd11;
  localparam logic [5:0] TOK_LEQ     = 6'd12;
  localparam logic [5:0] TOK_GTR     = 6'd13;
  localparam logic [5:0] TOK_GEQ     = 6'd14;
  localparam logic [5:0] TOK_LPAREN  = 6'd15;
  localparam logic [5:0] TOK_RPAREN  = 6'd16;
  localparam logic [5:0] TOK_COMMA   = 6'd17;
  localparam logic [5:0] TOK_SEMI    = 6'd18;
  localparam logic [5:0] TOK_PERIOD  = 6'd19;
  localparam logic [5:0] TOK_BECOMES = 6'd20;

  // error kinds
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ID_LONG  = 2'd1;
  localparam logic [1:0] ERR_NUM_LONG = 2'd2;
  localparam logic [1:0] ERR_INVALID  = 2'd3;

  // ascii codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  // reserved words, first character in the low byte
  localparam logic [87:0] KwText [KwCount] = '{
    88'h74736e6f63,         // const
    88'h726176,             // var
    88'h6572756465636f7270, // procedure
    88'h6c6c6163,           // call
    88'h6e69676562,         // begin
    88'h646e65,             // end
    88'h6669,               // if
    88'h6966,               // fi
    88'h6e656874,           // then
    88'h65736c65,           // else
    88'h656c696877,         // while
    88'h6f64,               // do
    88'h64616572,           // read
    88'h6574697277          // write
  };
  localparam logic [3:0] KwLen [KwCount] = '{
    4'd5, 4'd3, 4'd9, 4'd4, 4'd5, 4'd3, 4'd2, 4'd2, 4'd4, 4'd4, 4'd5, 4'd2, 4'd4, 4'd5
  };
  localparam logic [5:0] KwTok [KwCount] = '{
    6'd28, 6'd29, 6'd30, 6'd27, 6'd21, 6'd22, 6'd23, 6'd8, 6'd24, 6'd33, 6'd25, 6'd26,
    6'd32, 6'd31
  };

  function automatic pl0_out_t mk_res(logic [5:0] tok, logic [1:0] kind, logic [3:0] len,
                                      logic [87:0] lex);
    pl0_out_t r;
    r.token_type    = tok;
    r.error_kind    = kind;
    r.lexeme_length = len;
    r.lexeme_head   = lex[63:0];
    r.lexeme_tail   = lex[87:64];
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

/* sv/pl0_scan.sv */
// scanner state and per-byte token logic: up to two results per transfer
`timescale 1ns / 1ps
module pl0_scan import pl0_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  pl0_in_t       in_data_i,
  output pl0_res_pair_t res_o
);

  typedef enum logic [9:0] {
    M_IDLE     = 10'b00_0000_0001,
    M_SLASH    = 10'b00_0000_0010,
    M_COMMENT  = 10'b00_0000_0100,
    M_IDENT    = 10'b00_0000_1000,
    M_NUMBER   = 10'b00_0001_0000,
    M_ID_SKIP  = 10'b00_0010_0000,
    M_NUM_SKIP = 10'b00_0100_0000,
    M_LT       = 10'b00_1000_0000,
    M_GT       = 10'b01_0000_0000,
    M_COLON    = 10'b10_0000_0000
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        star_q, star_d;
  logic [7:0]  store_q [LexDepth];
  logic        store_we;
  logic [3:0]  store_idx;

  logic [7:0]  c;
  logic        is_blank, is_alpha, is_digit, is_alnum;
  logic [87:0] lex;
  logic [5:0]  id_tok;

  logic        idle_v, idle_load;
  logic [5:0]  idle_tok;
  logic [1:0]  idle_kind;
  mode_e       idle_mode;

  logic        pre_v, post_v, go_idle;
  pl0_out_t    pre_res, post_res, sym_res;

  assign c        = in_data_i.ch;
  assign is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alnum = is_alpha || is_digit;

  // stored characters past the count read as zero
  always_comb begin
    for (int i = 0; i < LexDepth; i++) begin
      lex[i*8 +: 8] = (4'(i) < cnt_q) ? store_q[i] : 8'h00;
    end
  end

  // parallel keyword compare
  always_comb begin
    id_tok = TOK_IDENT;
    for (int k = KwCount - 1; k >= 0; k--) begin
      if ((cnt_q == KwLen[k]) && (lex == KwText[k])) begin
        id_tok = KwTok[k];
      end
    end
  end

  // what a byte does when seen with nothing pending
  always_comb begin
    idle_v    = 1'b0;
    idle_load = 1'b0;
    idle_tok  = TOK_ERR;
    idle_kind = ERR_NONE;
    idle_mode = M_IDLE;
    if (is_blank) begin
      idle_mode = M_IDLE;
    end else if (is_alpha) begin
      idle_load = 1'b1;
      idle_mode = M_IDENT;
    end else if (is_digit) begin
      idle_load = 1'b1;
      idle_mode = M_NUMBER;
    end else begin
      unique case (c)
        CH_SLASH:  idle_mode = M_SLASH;
        CH_LT:     idle_mode = M_LT;
        CH_GT:     idle_mode = M_GT;
        CH_COLON:  idle_mode = M_COLON;
        CH_PLUS:   begin idle_v = 1'b1; idle_tok = TOK_PLUS;   end
        CH_MINUS:  begin idle_v = 1'b1; idle_tok = TOK_MINUS;  end
        CH_STAR:   begin idle_v = 1'b1; idle_tok = TOK_MULT;   end
        CH_LPAREN: begin idle_v = 1'b1; idle_tok = TOK_LPAREN; end
        CH_RPAREN: begin idle_v = 1'b1; idle_tok = TOK_RPAREN; end
        CH_EQ:     begin idle_v = 1'b1; idle_tok = TOK_EQL;    end
        CH_COMMA:  begin idle_v = 1'b1; idle_tok = TOK_COMMA;  end
        CH_PERIOD: begin idle_v = 1'b1; idle_tok = TOK_PERIOD; end
        CH_SEMI:   begin idle_v = 1'b1; idle_tok = TOK_SEMI;   end
        default: begin
          idle_v    = 1'b1;
          idle_tok  = TOK_ERR;
          idle_kind = ERR_INVALID;
        end
      endcase
    end
  end

  // token still held by the current mode
  always_comb begin
    unique case (mode_q)
      M_SLASH, M_COMMENT: sym_res = mk_res(TOK_SLASH, ERR_NONE, 4'd1, {80'd0, CH_SLASH});
      M_IDENT:            sym_res = mk_res(id_tok, ERR_NONE, cnt_q, lex);
      M_NUMBER:           sym_res = mk_res(TOK_NUMBER, ERR_NONE, cnt_q, lex);
      M_LT:               sym_res = mk_res(TOK_LES, ERR_NONE, 4'd1, {80'd0, CH_LT});
      M_GT:               sym_res = mk_res(TOK_GTR, ERR_NONE, 4'd1, {80'd0, CH_GT});
      M_COLON:            sym_res = mk_res(TOK_ERR, ERR_INVALID, 4'd1, {80'd0, CH_COLON});
      default:            sym_res = mk_res(TOK_ERR, ERR_NONE, 4'd0, 88'd0);
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    star_d    = star_q;
    store_we  = 1'b0;
    store_idx = cnt_q;
    pre_v     = 1'b0;
    pre_res   = sym_res;
    post_v    = 1'b0;
    post_res  = mk_res(idle_tok, idle_kind, 4'd1, {80'd0, c});
    go_idle   = 1'b0;

    if (in_data_i.end_of_input) begin
      unique case (mode_q)
        M_SLASH, M_IDENT, M_NUMBER, M_LT, M_GT, M_COLON: pre_v = 1'b1;
        M_COMMENT: begin
          // unclosed comment gives back its opener
          pre_v    = 1'b1;
          post_v   = 1'b1;
          post_res = mk_res(TOK_MULT, ERR_NONE, 4'd1, {80'd0, CH_STAR});
        end
        default: pre_v = 1'b0;
      endcase
      mode_d = M_IDLE;
      cnt_d  = 4'd0;
      star_d = 1'b0;
    end else begin
      unique case (mode_q)
        M_IDLE: go_idle = 1'b1;
        M_SLASH: begin
          if (c == CH_STAR) begin
            mode_d = M_COMMENT;
            star_d = 1'b0;
          end else begin
            pre_v   = 1'b1;
            go_idle = 1'b1;
          end
        end
        M_COMMENT: begin
          if (star_q && (c == CH_SLASH)) begin
            mode_d = M_IDLE;
            star_d = 1'b0;
          end else begin
            star_d = (c == CH_STAR);
          end
        end
        M_IDENT: begin
          if (is_alnum) begin
            if (cnt_q < 4'(IdChars)) begin
              store_we = 1'b1;
              cnt_d    = cnt_q + 4'd1;
            end else begin
              pre_v   = 1'b1;
              pre_res = mk_res(TOK_ERR, ERR_ID_LONG, cnt_q, lex);
              mode_d  = M_ID_SKIP;
            end
          end else begin
            pre_v   = 1'b1;
            go_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit) begin
            if (cnt_q < 4'(NumDigits)) begin
              store_we = 1'b1;
              cnt_d    = cnt_q + 4'd1;
            end else begin
              pre_v   = 1'b1;
              pre_res = mk_res(TOK_ERR, ERR_NUM_LONG, cnt_q, lex);
              mode_d  = M_NUM_SKIP;
            end
          end else begin
            pre_v   = 1'b1;
            go_idle = 1'b1;
          end
        end
        M_ID_SKIP:  go_idle = !is_alnum;
        M_NUM_SKIP: go_idle = !is_digit;
        M_LT: begin
          pre_v = 1'b1;
          if (c == CH_EQ) begin
            pre_res = mk_res(TOK_LEQ, ERR_NONE, 4'd2, {72'd0, CH_EQ, CH_LT});
            mode_d  = M_IDLE;
          end else if (c == CH_GT) begin
            pre_res = mk_res(TOK_NEQ, ERR_NONE, 4'd2, {72'd0, CH_GT, CH_LT});
            mode_d  = M_IDLE;
          end else begin
            go_idle = 1'b1;
          end
        end
        M_GT: begin
          pre_v = 1'b1;
          if (c == CH_EQ) begin
            pre_res = mk_res(TOK_GEQ, ERR_NONE, 4'd2, {72'd0, CH_EQ, CH_GT});
            mode_d  = M_IDLE;
          end else begin
            go_idle = 1'b1;
          end
        end
        M_COLON: begin
          pre_v = 1'b1;
          if (c == CH_EQ) begin
            pre_res = mk_res(TOK_BECOMES, ERR_NONE, 4'd2, {72'd0, CH_EQ, CH_COLON});
            mode_d  = M_IDLE;
          end else begin
            go_idle = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase

      // the byte that did not extend the pending token starts afresh
      if (go_idle) begin
        mode_d = idle_mode;
        post_v = idle_v;
        if (idle_load) begin
          store_we  = 1'b1;
          store_idx = 4'd0;
          cnt_d     = 4'd1;
        end
      end
    end
  end

  always_comb begin
    res_o.push0     = accept_i && (pre_v || post_v);
    res_o.push1     = accept_i && pre_v && post_v;
    res_o.res0      = pre_v ? pre_res : post_res;
    res_o.res0.last = !(pre_v && post_v);
    res_o.res1      = post_res;
    res_o.res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cnt_q  <= 4'd0;
      star_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      star_q <= star_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && store_we) begin
      store_q[store_idx] <= c;
    end
  end

endmodule

/* sv/pl0_ofifo.sv */
// four-entry result queue taking one or two results per cycle
`timescale 1ns / 1ps
module pl0_ofifo import pl0_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pl0_res_pair_t res_i,
  output logic          room_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pl0_out_t      out_data_o
);

  pl0_out_t   mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [2:0] n_push;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = mem_q[rd_q];
  // room for the worst case of two results
  assign room_o      = (cnt_q <= 3'd2);
  assign n_push      = {1'b0, res_i.push0 && res_i.push1, res_i.push0 ^ res_i.push1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_q + n_push[1:0];
      if (pop) begin
        rd_q <= rd_q + 2'd1;
      end
      cnt_q <= cnt_q + n_push - {2'b00, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.push0) begin
      mem_q[wr_q] <= res_i.res0;
    end
    if (res_i.push1) begin
      mem_q[wr_q + 2'd1] <= res_i.res1;
    end
  end

endmodule

/* sv/pl0_lexer_top.sv */
// top level of the pl0 lexer: scanner plus result queue
`timescale 1ns / 1ps
// Streaming PL/0 tokenizer. Each transfer on the input carries one source byte or an end
// marker; the scanner handles it in the cycle it is taken and writes zero, one or two tokens
// into a four-entry result queue, from which the output is read. A byte is taken every
// cycle while the queue has room for two tokens; a byte that closes a pending token and
// also yields a symbol of its own puts two tokens in the queue, and the input slows only
// if the consumer cannot drain them. Lexemes come out with the first character in the low
// byte of lexeme_head and unused bytes zero.
module pl0_lexer_top import pl0_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pl0_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pl0_out_t out_data_o
);

  logic          accept;
  logic          room;
  pl0_res_pair_t res;

  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  pl0_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .res_o     (res)
  );

  pl0_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* sim/pl0_lexer_checker.sv */
// checker for the pl0 lexer: predicts tokens from accepted source bytes and compares them
`timescale 1ns / 1ps
module pl0_lexer_checker import pl0_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  pl0_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  pl0_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  typedef enum logic [3:0] {
    SC_IDLE, SC_SLASH, SC_COMMENT, SC_IDENT, SC_NUMBER, SC_ID_SKIP, SC_NUM_SKIP,
    SC_LT, SC_GT, SC_COLON
  } scan_e;

  // reserved word token numbers
  localparam logic [5:0] TOK_FI        = 6'd8;
  localparam logic [5:0] TOK_BEGIN     = 6'd21;
  localparam logic [5:0] TOK_END       = 6'd22;
  localparam logic [5:0] TOK_IF        = 6'd23;
  localparam logic [5:0] TOK_THEN      = 6'd24;
  localparam logic [5:0] TOK_WHILE     = 6'd25;
  localparam logic [5:0] TOK_DO        = 6'd26;
  localparam logic [5:0] TOK_CALL      = 6'd27;
  localparam logic [5:0] TOK_CONST     = 6'd28;
  localparam logic [5:0] TOK_VAR       = 6'd29;
  localparam logic [5:0] TOK_PROCEDURE = 6'd30;
  localparam logic [5:0] TOK_WRITE     = 6'd31;
  localparam logic [5:0] TOK_READ      = 6'd32;
  localparam logic [5:0] TOK_ELSE      = 6'd33;

  scan_e      mode;
  logic [7:0] word [LexDepth];
  logic [3:0] count;
  logic       star_seen;
  pl0_out_t   expected_tokens [$];
  int         fails = 0;

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [87:0] word_bits();
    logic [87:0] v;
    v = '0;
    for (int i = 0; i < LexDepth; i++)
      if (i < count) v[8*i +: 8] = word[i];
    return v;
  endfunction

  function automatic logic [5:0] word_token();
    logic [87:0] text;
    text = '0;
    // first character ends up in the high byte so it lines up with a string literal
    for (int i = 0; i < LexDepth; i++)
      if (i < count) text = {text[79:0], word[i]};
    case (text)
      {48'd0, "const"}:     return TOK_CONST;
      {64'd0, "var"}:       return TOK_VAR;
      {16'd0, "procedure"}: return TOK_PROCEDURE;
      {56'd0, "call"}:      return TOK_CALL;
      {48'd0, "begin"}:     return TOK_BEGIN;
      {64'd0, "end"}:       return TOK_END;
      {72'd0, "if"}:        return TOK_IF;
      {72'd0, "fi"}:        return TOK_FI;
      {56'd0, "then"}:      return TOK_THEN;
      {56'd0, "else"}:      return TOK_ELSE;
      {48'd0, "while"}:     return TOK_WHILE;
      {72'd0, "do"}:        return TOK_DO;
      {56'd0, "read"}:      return TOK_READ;
      {48'd0, "write"}:     return TOK_WRITE;
      default:              return TOK_IDENT;
    endcase
  endfunction

  task automatic queue_token(logic [5:0] tok, logic [1:0] kind, logic [3:0] len,
                             logic [87:0] lex);
    pl0_out_t t;
    t.token_type    = tok;
    t.error_kind    = kind;
    t.lexeme_length = len;
    t.lexeme_head   = lex[63:0];
    t.lexeme_tail   = lex[87:64];
    t.last          = 1'b0;
    expected_tokens.push_back(t);
  endtask

  task automatic queue_symbol(logic [5:0] tok, logic [7:0] c);
    queue_token(tok, ERR_NONE, 4'd1, {80'd0, c});
  endtask

  task automatic queue_pair(logic [5:0] tok, logic [7:0] c0, logic [7:0] c1);
    queue_token(tok, ERR_NONE, 4'd2, {72'd0, c1, c0});
  endtask

  task automatic queue_invalid(logic [7:0] c);
    queue_token(TOK_ERR, ERR_INVALID, 4'd1, {80'd0, c});
  endtask

  task automatic start_lexeme(logic [7:0] c);
    mode = SC_IDLE;
    if (is_blank(c)) begin
      mode = SC_IDLE;
    end else if (is_alpha(c) || is_digit(c)) begin
      word[0] = c;
      count   = 4'd1;
      mode    = is_alpha(c) ? SC_IDENT : SC_NUMBER;
    end else begin
      case (c)
        CH_SLASH:  mode = SC_SLASH;
        CH_LT:     mode = SC_LT;
        CH_GT:     mode = SC_GT;
        CH_COLON:  mode = SC_COLON;
        CH_PLUS:   queue_symbol(TOK_PLUS, c);
        CH_MINUS:  queue_symbol(TOK_MINUS, c);
        CH_STAR:   queue_symbol(TOK_MULT, c);
        CH_LPAREN: queue_symbol(TOK_LPAREN, c);
        CH_RPAREN: queue_symbol(TOK_RPAREN, c);
        CH_EQ:     queue_symbol(TOK_EQL, c);
        CH_COMMA:  queue_symbol(TOK_COMMA, c);
        CH_PERIOD: queue_symbol(TOK_PERIOD, c);
        CH_SEMI:   queue_symbol(TOK_SEMI, c);
        default:   queue_invalid(c);
      endcase
    end
  endtask

  task automatic scan_byte(pl0_in_t item);
    int         prior_size;
    logic [7:0] c;
    pl0_out_t   t;
    prior_size = expected_tokens.size();
    c = item.ch;
    if (item.end_of_input) begin
      case (mode)
        SC_SLASH:  queue_symbol(TOK_SLASH, CH_SLASH);
        // unclosed comment gives back its opener as two tokens
        SC_COMMENT: begin
          queue_symbol(TOK_SLASH, CH_SLASH);
          queue_symbol(TOK_MULT, CH_STAR);
        end
        SC_IDENT:  queue_token(word_token(), ERR_NONE, count, word_bits());
        SC_NUMBER: queue_token(TOK_NUMBER, ERR_NONE, count, word_bits());
        SC_LT:     queue_symbol(TOK_LES, CH_LT);
        SC_GT:     queue_symbol(TOK_GTR, CH_GT);
        SC_COLON:  queue_invalid(CH_COLON);
        default: ;
      endcase
      mode      = SC_IDLE;
      count     = 4'd0;
      star_seen = 1'b0;
    end else begin
      case (mode)
        SC_SLASH: begin
          if (c == CH_STAR) begin
            mode      = SC_COMMENT;
            star_seen = 1'b0;
          end else begin
            queue_symbol(TOK_SLASH, CH_SLASH);
            start_lexeme(c);
          end
        end
        SC_COMMENT: begin
          if (star_seen && c == CH_SLASH) begin
            mode      = SC_IDLE;
            star_seen = 1'b0;
          end else begin
            star_seen = (c == CH_STAR);
          end
        end
        SC_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (count < IdChars) begin
              word[count] = c;
              count++;
            end else begin
              queue_token(TOK_ERR, ERR_ID_LONG, count, word_bits());
              mode = SC_ID_SKIP;
            end
          end else begin
            queue_token(word_token(), ERR_NONE, count, word_bits());
            start_lexeme(c);
          end
        end
        SC_NUMBER: begin
          if (is_digit(c)) begin
            if (count < NumDigits) begin
              word[count] = c;
              count++;
            end else begin
              queue_token(TOK_ERR, ERR_NUM_LONG, count, word_bits());
              mode = SC_NUM_SKIP;
            end
          end else begin
            queue_token(TOK_NUMBER, ERR_NONE, count, word_bits());
            start_lexeme(c);
          end
        end
        SC_ID_SKIP: if (!(is_alpha(c) || is_digit(c))) start_lexeme(c);
        SC_NUM_SKIP: if (!is_digit(c)) start_lexeme(c);
        SC_LT: begin
          if (c == CH_EQ) begin
            queue_pair(TOK_LEQ, CH_LT, CH_EQ);
            mode = SC_IDLE;
          end else if (c == CH_GT) begin
            queue_pair(TOK_NEQ, CH_LT, CH_GT);
            mode = SC_IDLE;
          end else begin
            queue_symbol(TOK_LES, CH_LT);
            start_lexeme(c);
          end
        end
        SC_GT: begin
          if (c == CH_EQ) begin
            queue_pair(TOK_GEQ, CH_GT, CH_EQ);
            mode = SC_IDLE;
          end else begin
            queue_symbol(TOK_GTR, CH_GT);
            start_lexeme(c);
          end
        end
        SC_COLON: begin
          if (c == CH_EQ) begin
            queue_pair(TOK_BECOMES, CH_COLON, CH_EQ);
            mode = SC_IDLE;
          end else begin
            queue_invalid(CH_COLON);
            start_lexeme(c);
          end
        end
        default: start_lexeme(c);
      endcase
    end
    // flag the final token of this byte
    if (expected_tokens.size() > prior_size) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pl0_out_t want;
    if (!rst_ni) begin
      mode      = SC_IDLE;
      count     = 4'd0;
      star_seen = 1'b0;
      expected_tokens.delete();
    end else begin
      // output first: a token never leaves in the cycle its byte is taken
      if (out_valid_i && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          fails++;
          $display("%0t: token transfer, expected none, actual %p", $time, out_data_i);
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_type", 64'(want.token_type), 64'(out_data_i.token_type));
          check_field("error_kind", 64'(want.error_kind), 64'(out_data_i.error_kind));
          check_field("lexeme_length", 64'(want.lexeme_length),
                      64'(out_data_i.lexeme_length));
          check_field("lexeme_head", want.lexeme_head, out_data_i.lexeme_head);
          check_field("lexeme_tail", 64'(want.lexeme_tail), 64'(out_data_i.lexeme_tail));
          check_field("last", 64'(want.last), 64'(out_data_i.last));
        end
      end
      if (in_valid_i && in_ready_i) scan_byte(in_data_i);
    end
    pending_o    <= expected_tokens.size();
    fail_count_o <= fails;
  end

endmodule

/* sim/testbench.sv */
// testbench top: drives source bytes into the pl0 lexer and gives the verdict
`timescale 1ns / 1ps
module testbench;
  import pl0_pkg::*;

  localparam int HoldCycles  = 200;
  localparam int PhaseItems  = 240;
  localparam int TailCycles  = 20;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  pl0_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  pl0_out_t out_data;
  int       fail_count;
  int       pending;

  int unsigned send_idle;
  int unsigned recv_stall;
  logic        hold_req;
  int          hold_at;
  pl0_in_t     source_bytes [$];
  string       keywords [14];
  string       operators;

  pl0_lexer_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  pl0_lexer_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void push_char(logic [7:0] c);
    pl0_in_t it;
    it.ch = c;
    it.end_of_input = 1'b0;
    source_bytes.push_back(it);
  endfunction

  function automatic void push_end(logic [7:0] c);
    pl0_in_t it;
    it.ch = c;
    it.end_of_input = 1'b1;
    source_bytes.push_back(it);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1) == 0) return 8'("a" + $urandom_range(25));
    return 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_blank();
    if ($urandom_range(2) == 0) return CH_SPACE;
    return 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  function automatic logic [7:0] rand_operator();
    return operators[$urandom_range(operators.len() - 1)];
  endfunction

  function automatic void push_separator();
    case ($urandom_range(4))
      0, 1: push_char(rand_blank());
      2:    push_char(rand_operator());
      3:    push_char(8'($urandom_range(255)));
      default: ;  // run straight into the next fragment
    endcase
  endfunction

  function automatic void push_comment_body();
    int n;
    n = $urandom_range(6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(4))
        0:       push_char(CH_STAR);
        1:       push_char(CH_SLASH);
        2:       push_char(rand_letter());
        3:       push_char(rand_blank());
        default: push_char(8'($urandom_range(255)));
      endcase
    end
  endfunction

  // one piece of source text; mostly well-formed lexemes, some noise
  function automatic void push_fragment();
    int n;
    case ($urandom_range(19))
      0, 1, 2: begin
        push_text(keywords[$urandom_range(13)]);
        push_separator();
      end
      3, 4, 5: begin
        n = ($urandom_range(7) == 0) ? $urandom_range(12, 15) : $urandom_range(1, 11);
        push_char(rand_letter());
        for (int i = 1; i < n; i++)
          push_char(($urandom_range(9) < 7) ? rand_letter() : rand_digit());
        push_separator();
      end
      6, 7: begin
        n = ($urandom_range(5) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) push_char(rand_digit());
        push_separator();
      end
      8, 9: push_char(rand_operator());
      10: begin
        case ($urandom_range(3))
          0:       push_text(":=");
          1:       push_text("<=");
          2:       push_text("<>");
          default: push_text(">=");
        endcase
      end
      11: begin
        // lookahead byte after a possible two-character start
        push_char(operators[$urandom_range(9, 12)]);
        push_char(($urandom_range(1) == 0) ? rand_operator() : 8'($urandom_range(255)));
      end
      12, 13: begin
        push_text("/*");
        push_comment_body();
        push_text("*/");
      end
      14: begin
        push_text("/*");
        push_comment_body();
        push_end(8'($urandom_range(255)));
      end
      15, 16: push_char(rand_blank());
      17, 18: push_char(8'($urandom_range(255)));
      default: push_end(8'($urandom_range(255)));
    endcase
  endfunction

  task automatic send_byte(pl0_in_t it);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // send everything queued, then wait for every token to come out
  task automatic send_all();
    for (int k = 0; k < source_bytes.size(); k++) begin
      if (k == hold_at) hold_req <= 1'b1;
      send_byte(source_bytes[k]);
    end
    source_bytes.delete();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    hold_req   <= 1'b0;
    send_idle  = 0;
    recv_stall = 0;
    hold_at    = -1;
    keywords   = '{"const", "var", "procedure", "call", "begin", "end", "if", "fi",
                   "then", "else", "while", "do", "read", "write"};
    operators  = "+-*()=,.;/<>:";
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: comment whose opener star does not close it, overlong number,
    // lone colon with lookahead, two tokens from one byte, byte extremes,
    // end in idle, overlong identifier, unclosed comment at end
    push_text("/*/*/");
    push_text("123456 ");
    push_text(":x");
    push_char(8'hFF);
    push_char(8'h00);
    push_end(8'hFF);
    push_text("abcdefghijkl<");
    push_text("/*");
    push_end(8'h00);
    send_all();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
          hold_at    = 40;
        end
        1: begin
          send_idle  = 87;
          recv_stall = 0;
          hold_at    = -1;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 87;
        end
        default: begin
          send_idle  = 7;
          recv_stall = 7;
        end
      endcase
      while (source_bytes.size() < PhaseItems) push_fragment();
      push_end(8'($urandom_range(255)));
      send_all();
    end

    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
